FILE: src/msd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Soft-start drive shared definitions
// Types, constants and the control program of the soft-start drive block.
// ----------------------------------------------------------------------------
package msd_pkg;

  // Field widths.
  localparam int ADC_W    = 12;
  localparam int PWM_W    = 8;
  localparam int PCT_W    = 7;
  localparam int BEEP_W   = 16;
  localparam int TIME_W   = 32;
  localparam int ACC_W    = 28;
  localparam int TOP_W    = 9;
  localparam int DIV_W    = 21;
  localparam int DCNT_W   = 5;
  localparam int PC_W     = 4;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  // Arithmetic constants.
  localparam logic [6:0]        LIMIT_SPAN     = 7'd89;   // 99 - 10
  localparam logic [6:0]        LIMIT_LOW      = 7'd10;
  localparam int                POT_SHIFT      = 12;      // divide by 4096
  localparam logic [PWM_W-1:0]  PWM_FULL       = 8'd255;
  localparam logic [12:0]       RECIP_100      = 13'd5243; // 2^19 / 100, rounded up
  localparam int                RECIP_SHIFT    = 19;
  localparam logic [PWM_W-1:0]  RAMP_THRESHOLD = 8'd15;
  localparam logic [PWM_W-1:0]  RAMP_DROP      = 8'd10;
  localparam logic [DCNT_W-1:0] DIV_STEPS      = 5'(DIV_W);

  // Result kinds and buzzer tones.
  localparam logic [1:0] KIND_RAMP  = 2'd0;
  localparam logic [1:0] KIND_STOP  = 2'd1;
  localparam logic [1:0] KIND_DRIVE = 2'd2;
  localparam logic [1:0] TONE_OFF   = 2'd0;
  localparam logic [1:0] TONE_REV   = 2'd1;
  localparam logic [1:0] TONE_HORN  = 2'd2;

  // Register indexes.
  localparam logic [2:0] REG_PEDAL_MIN = 3'd0;
  localparam logic [2:0] REG_PEDAL_MAX = 3'd1;
  localparam logic [2:0] REG_REV_CAP   = 3'd2;
  localparam logic [2:0] REG_SLEW      = 3'd3;
  localparam logic [2:0] REG_DEAD_BAND = 3'd4;
  localparam logic [2:0] REG_BEEP      = 3'd5;

  // Datapath operations.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_LIM_MUL,
    OP_LIM_SEL,
    OP_TOP_MUL,
    OP_TOP_DIV,
    OP_NUM_MUL,
    OP_DIV_STEP,
    OP_TARGET,
    OP_RAMP,
    OP_SLEW,
    OP_DBAND,
    OP_BUZZ,
    OP_EMIT
  } dp_op_t;

  // Conditions for waits and jumps.
  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_NEVER,
    COND_IN_VALID,
    COND_OUT_FREE,
    COND_NO_CHANGE,
    COND_LEVEL_HIGH,
    COND_DIV_BUSY
  } cond_t;

  typedef logic [PC_W-1:0] pc_t;

  typedef struct packed {
    dp_op_t op;
    cond_t  wait_c;
    cond_t  br_c;
    pc_t    target;
  } ucode_t;

  typedef struct packed {
    dp_op_t op;
    logic   fire;
  } ctl_t;

  typedef struct packed {
    logic no_change;
    logic level_high;
    logic div_busy;
  } dp_stat_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic no_change;
    logic level_high;
    logic div_busy;
  } cond_in_t;

  typedef struct packed {
    logic [ADC_W-1:0]  pedal_min;
    logic [ADC_W-1:0]  pedal_max;
    logic [PCT_W-1:0]  rev_cap;
    logic [PWM_W-1:0]  slew_step;
    logic [PWM_W-1:0]  dead_band;
    logic [BEEP_W-1:0] beep_interval;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    logic [PWM_W-1:0] fwd;
    logic [PWM_W-1:0] rev;
    logic [1:0]       tone;
    logic [1:0]       kind;
    logic             last;
  } emit_t;

  // Program steps that are jump targets.
  localparam pc_t STEP_LOAD = 4'd0;
  localparam pc_t STEP_DIV  = 4'd6;
  localparam pc_t STEP_RAMP = 4'd8;
  localparam pc_t STEP_SLEW = 4'd9;

  // Control program, one word per step.
  function automatic ucode_t ucode_rom(input pc_t pc);
    ucode_t w;
    w = '{op: OP_NOP, wait_c: COND_ALWAYS, br_c: COND_ALWAYS, target: STEP_LOAD};
    case (pc)
      4'd0:  w = '{OP_LOAD,     COND_IN_VALID, COND_NEVER,      STEP_LOAD};
      4'd1:  w = '{OP_LIM_MUL,  COND_ALWAYS,   COND_NEVER,      STEP_LOAD};
      4'd2:  w = '{OP_LIM_SEL,  COND_ALWAYS,   COND_NEVER,      STEP_LOAD};
      4'd3:  w = '{OP_TOP_MUL,  COND_ALWAYS,   COND_NEVER,      STEP_LOAD};
      4'd4:  w = '{OP_TOP_DIV,  COND_ALWAYS,   COND_NEVER,      STEP_LOAD};
      4'd5:  w = '{OP_NUM_MUL,  COND_ALWAYS,   COND_NEVER,      STEP_LOAD};
      4'd6:  w = '{OP_DIV_STEP, COND_ALWAYS,   COND_DIV_BUSY,   STEP_DIV};
      4'd7:  w = '{OP_TARGET,   COND_ALWAYS,   COND_NO_CHANGE,  STEP_SLEW};
      4'd8:  w = '{OP_RAMP,     COND_OUT_FREE, COND_LEVEL_HIGH, STEP_RAMP};
      4'd9:  w = '{OP_SLEW,     COND_ALWAYS,   COND_NEVER,      STEP_LOAD};
      4'd10: w = '{OP_DBAND,    COND_ALWAYS,   COND_NEVER,      STEP_LOAD};
      4'd11: w = '{OP_BUZZ,     COND_ALWAYS,   COND_NEVER,      STEP_LOAD};
      4'd12: w = '{OP_EMIT,     COND_OUT_FREE, COND_ALWAYS,     STEP_LOAD};
      default: w = '{OP_NOP,    COND_ALWAYS,   COND_ALWAYS,     STEP_LOAD};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

FILE: src/msd_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Soft-start drive sequencer
// Step counter over the control program with wait and jump conditions.
// ----------------------------------------------------------------------------
module msd_seq (
  input  wire               clk,
  input  wire               rst_n,
  input  msd_pkg::cond_in_t cond_in,
  output msd_pkg::ctl_t     ctl
);
  import msd_pkg::*;

  pc_t    pc_r, pc_nxt;
  ucode_t uw;
  logic   wait_ok, br_ok;

  // Evaluate one condition code against the status inputs.
  function automatic logic cond_true(input cond_t c, input cond_in_t s);
    logic r;
    r = 1'b0;
    unique case (c)
      COND_ALWAYS:     r = 1'b1;
      COND_NEVER:      r = 1'b0;
      COND_IN_VALID:   r = s.in_valid;
      COND_OUT_FREE:   r = s.out_free;
      COND_NO_CHANGE:  r = s.no_change;
      COND_LEVEL_HIGH: r = s.level_high;
      COND_DIV_BUSY:   r = s.div_busy;
      default:         r = 1'b0;
    endcase
    return r;
  endfunction

  // Fetch the control word and decide the next step.
  always_comb begin
    uw      = ucode_rom(pc_r);
    wait_ok = cond_true(uw.wait_c, cond_in);
    br_ok   = cond_true(uw.br_c, cond_in);
    if (!wait_ok) begin
      pc_nxt = pc_r;
    end else if (br_ok) begin
      pc_nxt = uw.target;
    end else begin
      pc_nxt = pc_r + 4'd1;
    end
  end

  assign ctl.op   = uw.op;
  assign ctl.fire = wait_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= STEP_LOAD;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  // The program has thirteen steps; the counter never leaves them.
  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n) pc_r <= 4'd12)
    else $error("step counter outside the program");

  // A stalled step keeps its place.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !ctl.fire |=> $stable(pc_r))
    else $error("step counter moved during a wait");

  // The division step loops back to itself while iterations remain.
  a_div_loop: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == OP_DIV_STEP && cond_in.div_busy) |=> pc_r == STEP_DIV)
    else $error("division loop left early");

endmodule
`default_nettype wire

FILE: src/msd_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Soft-start drive datapath
// Operand registers, multiply steps, restoring divider and drive state.
// ----------------------------------------------------------------------------
module msd_dpath (
  input  wire                              clk,
  input  wire                              rst_n,
  input  msd_pkg::ctl_t                    ctl,
  input  msd_pkg::cfg_t                    cfg,
  input  wire  [msd_pkg::ADC_W-1:0]        pedal_value,
  input  wire  [msd_pkg::ADC_W-1:0]        limit_pot,
  input  wire                              gear_reverse,
  input  wire                              horn_pressed,
  input  wire  [msd_pkg::TIME_W-1:0]       now_ms,
  output msd_pkg::dp_stat_t                stat,
  output msd_pkg::emit_t                   emit
);
  import msd_pkg::*;

  // Tick operands.
  logic [ADC_W-1:0]  pedal_r, pedal_nxt;
  logic [ADC_W-1:0]  pot_r, pot_nxt;
  logic              rev_r, rev_nxt;
  logic              horn_r, horn_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  // Working registers.
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [PCT_W-1:0]  lvl_r, lvl_nxt;
  logic [DIV_W-1:0]  dvd_r, dvd_nxt;
  logic [ADC_W-1:0]  rem_r, rem_nxt;
  logic [ADC_W-1:0]  den_r, den_nxt;
  logic              kill_r, kill_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic [PWM_W-1:0]  target_r, target_nxt;
  // Drive state.
  logic [PWM_W-1:0]  level_r, level_nxt;
  logic              prev_rev_r, prev_rev_nxt;
  logic              phase_r, phase_nxt;
  logic [TIME_W-1:0] last_beep_r, last_beep_nxt;
  logic [1:0]        held_tone_r, held_tone_nxt;

  logic [ADC_W-1:0]  diff_mag;
  logic [ADC_W:0]    partial;
  logic [PWM_W:0]    sum9, tgt9;
  logic [TIME_W-1:0] beep_age;
  logic [PWM_W-1:0]  ramp_level;
  logic              level_high;

  assign level_high = level_r > RAMP_THRESHOLD;
  assign ramp_level = level_r - RAMP_DROP;

  assign stat.no_change  = rev_r == prev_rev_r;
  assign stat.level_high = level_high;
  assign stat.div_busy   = cnt_r != 5'd1;

  // Operation decode.
  always_comb begin
    pedal_nxt     = pedal_r;
    pot_nxt       = pot_r;
    rev_nxt       = rev_r;
    horn_nxt      = horn_r;
    now_nxt       = now_r;
    acc_nxt       = acc_r;
    lvl_nxt       = lvl_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    den_nxt       = den_r;
    kill_nxt      = kill_r;
    cnt_nxt       = cnt_r;
    target_nxt    = target_r;
    level_nxt     = level_r;
    prev_rev_nxt  = prev_rev_r;
    phase_nxt     = phase_r;
    last_beep_nxt = last_beep_r;
    held_tone_nxt = held_tone_r;
    diff_mag      = (pedal_r >= cfg.pedal_min) ? pedal_r - cfg.pedal_min
                                               : cfg.pedal_min - pedal_r;
    partial       = {rem_r, dvd_r[DIV_W-1]};
    sum9          = {1'b0, level_r} + {1'b0, cfg.slew_step};
    tgt9          = {1'b0, target_r} + {1'b0, cfg.slew_step};
    beep_age      = now_r - last_beep_r;
    emit          = '0;

    if (ctl.fire) begin
      case (ctl.op)
        OP_LOAD: begin
          pedal_nxt = pedal_value;
          pot_nxt   = limit_pot;
          rev_nxt   = gear_reverse;
          horn_nxt  = horn_pressed;
          now_nxt   = now_ms;
        end
        // Limit pot scaled to 10..98 percent.
        OP_LIM_MUL: acc_nxt = ACC_W'(pot_r) * ACC_W'(LIMIT_SPAN);
        OP_LIM_SEL: begin
          lvl_nxt = rev_r ? cfg.rev_cap
                          : PCT_W'(acc_r[POT_SHIFT +: PCT_W]) + LIMIT_LOW;
        end
        // Top of the pedal range: 255 * percent / 100.
        OP_TOP_MUL: acc_nxt = ACC_W'(lvl_r) * ACC_W'(PWM_FULL);
        OP_TOP_DIV: acc_nxt = ACC_W'(acc_r[14:0]) * ACC_W'(RECIP_100);
        // Numerator magnitude, divisor magnitude and the cases that give zero.
        OP_NUM_MUL: begin
          dvd_nxt  = DIV_W'(diff_mag) * DIV_W'(acc_r[RECIP_SHIFT +: TOP_W]);
          den_nxt  = (cfg.pedal_max >= cfg.pedal_min) ? cfg.pedal_max - cfg.pedal_min
                                                      : cfg.pedal_min - cfg.pedal_max;
          kill_nxt = (cfg.pedal_max == cfg.pedal_min) ||
                     ((pedal_r < cfg.pedal_min) != (cfg.pedal_max < cfg.pedal_min));
          rem_nxt  = '0;
          cnt_nxt  = DIV_STEPS;
        end
        // One quotient bit per step.
        OP_DIV_STEP: begin
          if (partial >= {1'b0, den_r}) begin
            rem_nxt = ADC_W'(partial - {1'b0, den_r});
            dvd_nxt = {dvd_r[DIV_W-2:0], 1'b1};
          end else begin
            rem_nxt = partial[ADC_W-1:0];
            dvd_nxt = {dvd_r[DIV_W-2:0], 1'b0};
          end
          cnt_nxt = cnt_r - 5'd1;
        end
        OP_TARGET: begin
          if (kill_r) begin
            target_nxt = '0;
          end else if (dvd_r[DIV_W-1:PWM_W] != '0) begin
            target_nxt = PWM_FULL;
          end else begin
            target_nxt = dvd_r[PWM_W-1:0];
          end
        end
        // Ramp the old direction down, or stop fully once low enough.
        OP_RAMP: begin
          emit.valid = 1'b1;
          emit.tone  = held_tone_r;
          emit.last  = 1'b0;
          if (level_high) begin
            level_nxt = ramp_level;
            emit.kind = KIND_RAMP;
            emit.fwd  = rev_r ? ramp_level : '0;
            emit.rev  = rev_r ? '0 : ramp_level;
          end else begin
            level_nxt    = '0;
            prev_rev_nxt = rev_r;
            emit.kind    = KIND_STOP;
          end
        end
        // Slew toward the target.
        OP_SLEW: begin
          if (level_r < target_r) begin
            level_nxt = (sum9 > {1'b0, target_r}) ? target_r : sum9[PWM_W-1:0];
          end else if (level_r > target_r) begin
            level_nxt = ({1'b0, level_r} < tgt9) ? target_r : level_r - cfg.slew_step;
          end
        end
        OP_DBAND: begin
          if (level_r < cfg.dead_band) begin
            level_nxt = '0;
          end
        end
        // Buzzer: reverse beep, horn, or silence.
        OP_BUZZ: begin
          if (rev_r) begin
            if (beep_age >= {16'd0, cfg.beep_interval}) begin
              last_beep_nxt = now_r;
              held_tone_nxt = phase_r ? TONE_OFF : TONE_REV;
              phase_nxt     = ~phase_r;
            end
          end else if (horn_r) begin
            held_tone_nxt = TONE_HORN;
          end else begin
            held_tone_nxt = TONE_OFF;
          end
        end
        OP_EMIT: begin
          emit.valid = 1'b1;
          emit.fwd   = rev_r ? '0 : level_r;
          emit.rev   = rev_r ? level_r : '0;
          emit.tone  = held_tone_r;
          emit.kind  = KIND_DRIVE;
          emit.last  = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    pedal_r  <= pedal_nxt;
    pot_r    <= pot_nxt;
    rev_r    <= rev_nxt;
    horn_r   <= horn_nxt;
    now_r    <= now_nxt;
    acc_r    <= acc_nxt;
    lvl_r    <= lvl_nxt;
    dvd_r    <= dvd_nxt;
    rem_r    <= rem_nxt;
    den_r    <= den_nxt;
    kill_r   <= kill_nxt;
    cnt_r    <= cnt_nxt;
    target_r <= target_nxt;
  end

  // Drive state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r     <= '0;
      prev_rev_r  <= 1'b0;
      phase_r     <= 1'b0;
      last_beep_r <= '0;
      held_tone_r <= TONE_OFF;
    end else begin
      level_r     <= level_nxt;
      prev_rev_r  <= prev_rev_nxt;
      phase_r     <= phase_nxt;
      last_beep_r <= last_beep_nxt;
      held_tone_r <= held_tone_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: src/motor_soft_start_drive.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Motor soft-start drive
// Per-tick pedal mapping, gear-change ramp-down, slew, dead band and buzzer.
// ----------------------------------------------------------------------------
// Each accepted tick word runs through a thirteen-step control program over
// one datapath. Its steps include a bit-serial divider that maps the pedal onto
// the drive range, and the load, buzzer and output steps. A gear change adds
// ramp-down words and a full-stop word before the drive word. The block
// takes the next tick word only when the program is back at its load step,
// and any result step waits while the output register still holds an unread
// word. Ramp-down and stop words come first, with last low; the drive word
// of the tick ends it with last high.
module motor_soft_start_drive (
  input  wire                          clk,
  input  wire                          rst_n,
  // Tick input
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  [msd_pkg::ADC_W-1:0]    in_pedal_value,
  input  wire  [msd_pkg::ADC_W-1:0]    in_limit_pot,
  input  wire                          in_gear_reverse,
  input  wire                          in_horn_pressed,
  input  wire  [msd_pkg::TIME_W-1:0]   in_now_ms,
  // Result output
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [msd_pkg::PWM_W-1:0]    out_forward_pwm,
  output logic [msd_pkg::PWM_W-1:0]    out_reverse_pwm,
  output logic [1:0]                   out_buzzer_tone,
  output logic [1:0]                   out_result_kind,
  output logic                         out_last,
  // Configuration
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [msd_pkg::ADDR_W-1:0]   paddr,
  input  wire  [msd_pkg::DATA_W-1:0]   pwdata,
  output logic [msd_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import msd_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  ctl_t     ctl;
  dp_stat_t stat;
  emit_t    emit;
  cond_in_t cond_in;
  logic     out_valid_r, out_valid_nxt;
  logic [PWM_W-1:0] out_fwd_r, out_rev_r;
  logic [1:0] out_tone_r, out_kind_r;
  logic       out_last_r;
  logic       out_free;
  logic       cfg_wr;
  logic [2:0] reg_idx;

  // Register file access.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];

  always_comb begin
    cfg_nxt = cfg_r;
    prdata  = '0;
    unique case (reg_idx)
      REG_PEDAL_MIN: begin
        prdata = DATA_W'(cfg_r.pedal_min);
        if (cfg_wr) cfg_nxt.pedal_min = pwdata[ADC_W-1:0];
      end
      REG_PEDAL_MAX: begin
        prdata = DATA_W'(cfg_r.pedal_max);
        if (cfg_wr) cfg_nxt.pedal_max = pwdata[ADC_W-1:0];
      end
      REG_REV_CAP: begin
        prdata = DATA_W'(cfg_r.rev_cap);
        if (cfg_wr) cfg_nxt.rev_cap = pwdata[PCT_W-1:0];
      end
      REG_SLEW: begin
        prdata = DATA_W'(cfg_r.slew_step);
        if (cfg_wr) cfg_nxt.slew_step = pwdata[PWM_W-1:0];
      end
      REG_DEAD_BAND: begin
        prdata = DATA_W'(cfg_r.dead_band);
        if (cfg_wr) cfg_nxt.dead_band = pwdata[PWM_W-1:0];
      end
      REG_BEEP: begin
        prdata = DATA_W'(cfg_r.beep_interval);
        if (cfg_wr) cfg_nxt.beep_interval = pwdata[BEEP_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pedal_min     <= 12'd850;
      cfg_r.pedal_max     <= 12'd2930;
      cfg_r.rev_cap       <= 7'd30;
      cfg_r.slew_step     <= 8'd5;
      cfg_r.dead_band     <= 8'd3;
      cfg_r.beep_interval <= 16'd500;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Status for the sequencer.
  assign out_free           = !out_valid_r || out_ready;
  assign cond_in.in_valid   = in_valid;
  assign cond_in.out_free   = out_free;
  assign cond_in.no_change  = stat.no_change;
  assign cond_in.level_high = stat.level_high;
  assign cond_in.div_busy   = stat.div_busy;

  assign in_ready = ctl.op == OP_LOAD;

  msd_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .cond_in (cond_in),
    .ctl     (ctl)
  );

  msd_dpath u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .cfg          (cfg_r),
    .pedal_value  (in_pedal_value),
    .limit_pot    (in_limit_pot),
    .gear_reverse (in_gear_reverse),
    .horn_pressed (in_horn_pressed),
    .now_ms       (in_now_ms),
    .stat         (stat),
    .emit         (emit)
  );

  // Output register: holds one word until it is taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit.valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      out_fwd_r  <= emit.fwd;
      out_rev_r  <= emit.rev;
      out_tone_r <= emit.tone;
      out_kind_r <= emit.kind;
      out_last_r <= emit.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_forward_pwm = out_fwd_r;
  assign out_reverse_pwm = out_rev_r;
  assign out_buzzer_tone = out_tone_r;
  assign out_result_kind = out_kind_r;
  assign out_last        = out_last_r;

  // A word is produced only when the output register can take it.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    emit.valid |-> out_free)
    else $error("result word overwrote an unread word");

  // Taking a tick and producing a result never coincide.
  a_load_vs_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> !emit.valid)
    else $error("tick accepted during a result step");

  // Only the drive word carries the last flag.
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_last_r == (out_kind_r == KIND_DRIVE)))
    else $error("last flag does not match the result kind");

endmodule
`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Soft-start drive testbench
// Drives tick words into the soft-start drive and checks every result word
// against a predictor of the pedal mapping, the gear-change ramp-down, the
// slew and dead band, and the buzzer. A short table of directed ticks runs
// first with the reset settings. After that come phases of random ticks, and
// each phase starts with new register settings written while the block is
// idle. The sender pauses between bursts of ticks and the receiver stalls on
// its own pattern.
// ----------------------------------------------------------------------------
module testbench;
  import msd_pkg::*;

  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int NUM_PHASES      = 8;
  localparam int TICKS_PER_PHASE = 33;
  localparam int NUM_DIRECTED    = 17;
  localparam int POT_SPAN        = 4096;
  localparam int PERCENT_FULL    = 100;

  // One tick word as the sender presents it.
  typedef struct packed {
    logic [ADC_W-1:0]  pedal_value;
    logic [ADC_W-1:0]  limit_pot;
    logic              gear_reverse;
    logic              horn_pressed;
    logic [TIME_W-1:0] now_ms;
  } tick_t;

  // One result word.
  typedef struct packed {
    logic [PWM_W-1:0] fwd;
    logic [PWM_W-1:0] rev;
    logic [1:0]       tone;
    logic [1:0]       kind;
    logic             last;
  } drive_word_t;

  // A directed tick, with a hand-written drive result where one is given.
  typedef struct packed {
    tick_t            tk;
    logic             typed;
    logic [PWM_W-1:0] fwd;
    logic [PWM_W-1:0] rev;
    logic [1:0]       tone;
  } tick_row_t;

  // A full set of register values.
  typedef struct packed {
    logic [ADC_W-1:0]  pedal_min;
    logic [ADC_W-1:0]  pedal_max;
    logic [PCT_W-1:0]  rev_cap;
    logic [PWM_W-1:0]  slew_step;
    logic [PWM_W-1:0]  dead_band;
    logic [BEEP_W-1:0] beep_interval;
  } settings_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [ADC_W-1:0]  in_pedal_value = '0;
  logic [ADC_W-1:0]  in_limit_pot = '0;
  logic              in_gear_reverse = 1'b0;
  logic              in_horn_pressed = 1'b0;
  logic [TIME_W-1:0] in_now_ms = '0;

  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [PWM_W-1:0]  out_forward_pwm;
  logic [PWM_W-1:0]  out_reverse_pwm;
  logic [1:0]        out_buzzer_tone;
  logic [1:0]        out_result_kind;
  logic              out_last;

  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  motor_soft_start_drive i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_pedal_value  (in_pedal_value),
    .in_limit_pot    (in_limit_pot),
    .in_gear_reverse (in_gear_reverse),
    .in_horn_pressed (in_horn_pressed),
    .in_now_ms       (in_now_ms),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_forward_pwm (out_forward_pwm),
    .out_reverse_pwm (out_reverse_pwm),
    .out_buzzer_tone (out_buzzer_tone),
    .out_result_kind (out_result_kind),
    .out_last        (out_last),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor copy of the registers and of the drive state.
  settings_t         drv_cfg;
  int unsigned       drive_level;
  logic              prev_reverse;
  logic              beep_on;
  logic [TIME_W-1:0] last_beep_ms;
  logic [1:0]        held_tone;

  drive_word_t pending_words[$];
  int          mismatch_cnt = 0;
  int          cycle_cnt = 0;
  int          burst_left = 0;

  function automatic void push_word(input int unsigned fwd, input int unsigned rev,
                                    input logic [1:0] tone, input logic [1:0] kind,
                                    input logic last);
    drive_word_t w;
    w.fwd  = fwd[PWM_W-1:0];
    w.rev  = rev[PWM_W-1:0];
    w.tone = tone;
    w.kind = kind;
    w.last = last;
    pending_words.push_back(w);
  endfunction

  // Linear pedal map onto 0..255*pct/100, truncating toward zero, saturated.
  function automatic int unsigned pedal_to_pwm(input logic [ADC_W-1:0] pedal,
                                               input int unsigned pct);
    longint top, den, num, lo, hi, t;
    lo  = longint'(drv_cfg.pedal_min);
    hi  = longint'(drv_cfg.pedal_max);
    num = longint'(pedal);
    top = (longint'(PWM_FULL) * longint'(pct)) / PERCENT_FULL;
    den = hi - lo;
    if (den == 0) begin
      return 0;
    end
    t = ((num - lo) * top) / den;
    if (t < 0) t = 0;
    if (t > PWM_FULL) t = PWM_FULL;
    return int'(t);
  endfunction

  // Works out every result word that one accepted tick causes.
  function automatic void compute_drive_words(input tick_t tk);
    int unsigned       limit_pct, pct, target;
    logic [1:0]        tone;
    logic [TIME_W-1:0] since_beep;
    limit_pct = 32'(tk.limit_pot);
    limit_pct = limit_pct * LIMIT_SPAN / POT_SPAN + LIMIT_LOW;

    // A gear change ramps the old direction down, then stops.
    if (tk.gear_reverse != prev_reverse) begin
      while (drive_level > RAMP_THRESHOLD) begin
        drive_level -= RAMP_DROP;
        if (tk.gear_reverse) push_word(drive_level, 0, held_tone, KIND_RAMP, 1'b0);
        else push_word(0, drive_level, held_tone, KIND_RAMP, 1'b0);
      end
      drive_level = 0;
      push_word(0, 0, held_tone, KIND_STOP, 1'b0);
      prev_reverse = tk.gear_reverse;
    end

    // Slew toward the target, then apply the dead band.
    pct = tk.gear_reverse ? int'(drv_cfg.rev_cap) : limit_pct;
    target = pedal_to_pwm(tk.pedal_value, pct);
    if (drive_level < target) begin
      drive_level += drv_cfg.slew_step;
      if (drive_level > target) drive_level = target;
    end else if (drive_level > target) begin
      if (drive_level < target + drv_cfg.slew_step) drive_level = target;
      else drive_level -= drv_cfg.slew_step;
    end
    if (drive_level < drv_cfg.dead_band) drive_level = 0;

    // Reverse beep toggles on its interval; otherwise horn or silence.
    tone = held_tone;
    if (tk.gear_reverse) begin
      since_beep = tk.now_ms - last_beep_ms;
      if (since_beep >= TIME_W'(drv_cfg.beep_interval)) begin
        last_beep_ms = tk.now_ms;
        tone = beep_on ? TONE_OFF : TONE_REV;
        beep_on = ~beep_on;
      end
    end else if (tk.horn_pressed) begin
      tone = TONE_HORN;
    end else begin
      tone = TONE_OFF;
    end
    held_tone = tone;

    if (tk.gear_reverse) push_word(0, drive_level, tone, KIND_DRIVE, 1'b1);
    else push_word(drive_level, 0, tone, KIND_DRIVE, 1'b1);
  endfunction

  // Presents one tick word and holds it until the block takes it.
  task automatic send_tick(input tick_t tk);
    in_valid        <= 1'b1;
    in_pedal_value  <= tk.pedal_value;
    in_limit_pot    <= tk.limit_pot;
    in_gear_reverse <= tk.gear_reverse;
    in_horn_pressed <= tk.horn_pressed;
    in_now_ms       <= tk.now_ms;
    do @(posedge clk); while (!in_ready);
    compute_drive_words(tk);
  endtask

  // Bursts of back-to-back ticks separated by random gaps.
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      burst_left = $urandom_range(0, 10);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops sending and waits until every expected word has come out.
  task automatic wait_drained(input int settle);
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Register write: setup cycle, then access cycle until pready, then idle.
  task automatic reg_write(input logic [2:0] idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_PEDAL_MIN: drv_cfg.pedal_min     = value[ADC_W-1:0];
      REG_PEDAL_MAX: drv_cfg.pedal_max     = value[ADC_W-1:0];
      REG_REV_CAP:   drv_cfg.rev_cap       = value[PCT_W-1:0];
      REG_SLEW:      drv_cfg.slew_step     = value[PWM_W-1:0];
      REG_DEAD_BAND: drv_cfg.dead_band     = value[PWM_W-1:0];
      REG_BEEP:      drv_cfg.beep_interval = value[BEEP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input settings_t s);
    reg_write(REG_PEDAL_MIN, DATA_W'(s.pedal_min));
    reg_write(REG_PEDAL_MAX, DATA_W'(s.pedal_max));
    reg_write(REG_REV_CAP,   DATA_W'(s.rev_cap));
    reg_write(REG_SLEW,      DATA_W'(s.slew_step));
    reg_write(REG_DEAD_BAND, DATA_W'(s.dead_band));
    reg_write(REG_BEEP,      DATA_W'(s.beep_interval));
  endtask

  // Directed ticks under the reset settings. Hand-written drive results only
  // where the value is obvious: pedal below the minimum, and the first slew
  // step from rest.
  tick_row_t directed_rows [NUM_DIRECTED] = '{
    '{'{12'd0,    12'd0,    1'b0, 1'b0, 32'd0},          1'b1, 8'd0, 8'd0, TONE_OFF},
    '{'{12'd0,    12'd0,    1'b0, 1'b1, 32'd10},         1'b1, 8'd0, 8'd0, TONE_HORN},
    '{'{12'd4095, 12'd4095, 1'b0, 1'b0, 32'd20},         1'b1, 8'd5, 8'd0, TONE_OFF},
    '{'{12'd4095, 12'd4095, 1'b0, 1'b1, 32'd30},         1'b0, 8'd0, 8'd0, TONE_OFF},
    '{'{12'd4095, 12'd4095, 1'b0, 1'b0, 32'd35},         1'b0, 8'd0, 8'd0, TONE_OFF},
    '{'{12'd4095, 12'd2048, 1'b0, 1'b0, 32'd38},         1'b0, 8'd0, 8'd0, TONE_OFF},
    '{'{12'd2000, 12'd0,    1'b1, 1'b0, 32'd40},         1'b0, 8'd0, 8'd0, TONE_OFF},
    '{'{12'd4095, 12'd4095, 1'b1, 1'b0, 32'd540},        1'b0, 8'd0, 8'd0, TONE_OFF},
    '{'{12'd4095, 12'd0,    1'b1, 1'b1, 32'd1039},       1'b0, 8'd0, 8'd0, TONE_OFF},
    '{'{12'd2930, 12'd4095, 1'b1, 1'b0, 32'd1040},       1'b0, 8'd0, 8'd0, TONE_OFF},
    '{'{12'd850,  12'd4095, 1'b0, 1'b1, 32'd1100},       1'b0, 8'd0, 8'd0, TONE_OFF},
    '{'{12'd100,  12'd100,  1'b1, 1'b0, 32'd1200},       1'b0, 8'd0, 8'd0, TONE_OFF},
    '{'{12'd4095, 12'd4095, 1'b1, 1'b0, 32'hFFFF_FFFF},  1'b0, 8'd0, 8'd0, TONE_OFF},
    '{'{12'd4095, 12'd4095, 1'b1, 1'b1, 32'h0000_00F0},  1'b0, 8'd0, 8'd0, TONE_OFF},
    '{'{12'd4095, 12'd4095, 1'b0, 1'b0, 32'd0},          1'b0, 8'd0, 8'd0, TONE_OFF},
    '{'{12'd1234, 12'hAAA,  1'b0, 1'b1, 32'h5555_5555},  1'b0, 8'd0, 8'd0, TONE_OFF},
    '{'{12'hFFF,  12'h555,  1'b0, 1'b0, 32'hAAAA_AAAA},  1'b0, 8'd0, 8'd0, TONE_OFF}
  };

  // Fixed settings first: both extremes of every register, equal and
  // inverted pedal bounds, a zero slew step and a zero beep interval.
  settings_t fixed_settings [4] = '{
    '{12'd0,    12'd4095, 7'd100, 8'd255, 8'd0,   16'd1},
    '{12'd2000, 12'd2000, 7'd0,   8'd0,   8'd255, 16'd0},
    '{12'd4095, 12'd0,    7'd127, 8'd17,  8'd1,   16'd65535},
    '{12'd850,  12'd2930, 7'd30,  8'd5,   8'd3,   16'd500}
  };

  // Main stimulus.
  initial begin
    tick_t       tk;
    drive_word_t w;
    settings_t   s;
    logic        rev_gear;
    logic [31:0] now;

    drv_cfg      = '{12'd850, 12'd2930, 7'd30, 8'd5, 8'd3, 16'd500};
    drive_level  = 0;
    prev_reverse = 1'b0;
    beep_on      = 1'b0;
    last_beep_ms = '0;
    held_tone    = TONE_OFF;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_tick(directed_rows[i].tk);
      if (directed_rows[i].typed) begin
        w = pending_words.pop_back();
        w.fwd  = directed_rows[i].fwd;
        w.rev  = directed_rows[i].rev;
        w.tone = directed_rows[i].tone;
        pending_words.push_back(w);
      end
      pace_sender();
    end

    rev_gear = 1'b0;
    now = 32'd5000;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drained(6);
      if (ph < 4) begin
        s = fixed_settings[ph];
      end else begin
        s.pedal_min     = ADC_W'($urandom_range(0, 4095));
        s.pedal_max     = ADC_W'($urandom_range(0, 4095));
        s.rev_cap       = PCT_W'($urandom_range(0, 127));
        s.slew_step     = PWM_W'($urandom_range(1, 60));
        s.dead_band     = PWM_W'($urandom_range(0, 60));
        s.beep_interval = BEEP_W'($urandom_range(0, 1500));
      end
      apply_settings(s);

      for (int n = 0; n < TICKS_PER_PHASE; n++) begin
        // Long runs in one gear with a mostly high pedal build the drive
        // level up, so that a gear change has a deep ramp to walk down.
        if ($urandom_range(0, 9) == 0) rev_gear = ~rev_gear;
        case ($urandom_range(0, 3))
          0: tk.pedal_value = ADC_W'($urandom_range(0, 4095));
          3: tk.pedal_value = ADC_W'($urandom_range(0, 900));
          default: tk.pedal_value = ADC_W'($urandom_range(3000, 4095));
        endcase
        tk.limit_pot    = ADC_W'($urandom_range(0, 4095));
        tk.gear_reverse = rev_gear;
        tk.horn_pressed = ($urandom_range(0, 2) == 0);
        if ($urandom_range(0, 15) == 0) now = $urandom;
        else now = now + $urandom_range(0, 700);
        tk.now_ms = now;
        send_tick(tk);
        // Once, hold off until the block has emptied completely.
        if (ph == 4 && n == TICKS_PER_PHASE / 2) wait_drained(0);
        else pace_sender();
      end
    end

    wait_drained(40);
    if (mismatch_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Receiver stall pattern: a new mode whenever its age counter wraps, either
  // always ready, randomly ready, or mostly ready with occasional long stalls.
  logic [5:0] rdy_age = '0;
  int         rdy_mode = 0;
  int         stall_left = 0;

  always @(posedge clk) begin
    rdy_age <= rdy_age + 6'd1;
    if (rdy_age == '0) rdy_mode <= $urandom_range(0, 2);
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else begin
      case (rdy_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 2) != 0);
        default: begin
          if ($urandom_range(0, 15) == 0) begin
            stall_left <= $urandom_range(1, 20);
            out_ready  <= 1'b0;
          end else begin
            out_ready <= 1'b1;
          end
        end
      endcase
    end
  end

  // Result checker: each accepted word against the oldest expected one.
  drive_word_t want;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        $error("unexpected result word: fwd %0d rev %0d tone %0d kind %0d last %0d",
               out_forward_pwm, out_reverse_pwm, out_buzzer_tone, out_result_kind,
               out_last);
        mismatch_cnt++;
      end else begin
        want = pending_words.pop_front();
        if (out_forward_pwm !== want.fwd) begin
          $error("forward_pwm: expected %0d, got %0d", want.fwd, out_forward_pwm);
          mismatch_cnt++;
        end
        if (out_reverse_pwm !== want.rev) begin
          $error("reverse_pwm: expected %0d, got %0d", want.rev, out_reverse_pwm);
          mismatch_cnt++;
        end
        if (out_buzzer_tone !== want.tone) begin
          $error("buzzer_tone: expected %0d, got %0d", want.tone, out_buzzer_tone);
          mismatch_cnt++;
        end
        if (out_result_kind !== want.kind) begin
          $error("result_kind: expected %0d, got %0d", want.kind, out_result_kind);
          mismatch_cnt++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_last);
          mismatch_cnt++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule
